// File: sv/pwop_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwop_pkg
// Shared types, codes and saturating helpers for the PID block.
// ----------------------------------------------------------------------------
package pwop_pkg;

    typedef enum logic [4:0] {
        ST_IDLE, ST_PRE, ST_EVAL, ST_PRED, ST_MULP, ST_MULM, ST_MULI, ST_MULD,
        ST_DRES, ST_DB1, ST_DB2, ST_AW1, ST_AW2, ST_INTG, ST_BASE, ST_DIV,
        ST_SCALE, ST_SCL2, ST_OUT
    } t_state;

    // register indexes
    localparam logic [2:0] CFG_KP    = 3'd0;
    localparam logic [2:0] CFG_KI    = 3'd1;
    localparam logic [2:0] CFG_KD    = 3'd2;
    localparam logic [2:0] CFG_LOW   = 3'd3;
    localparam logic [2:0] CFG_HIGH  = 3'd4;
    localparam logic [2:0] CFG_PF    = 3'd5;
    localparam logic [2:0] CFG_BAND  = 3'd6;
    localparam logic [2:0] CFG_OPT   = 3'd7;

    // request modes
    localparam logic [1:0] OP_SAMPLE = 2'd0;
    localparam logic [1:0] OP_INIT   = 2'd1;
    localparam logic [1:0] OP_RESET  = 2'd2;
    localparam logic [1:0] OP_LOAD   = 2'd3;

    // proportional and windup modes
    localparam logic [1:0] PM_ERR    = 2'd0;
    localparam logic [1:0] PM_MEAS   = 2'd1;
    localparam logic [1:0] WM_COND   = 2'd0;
    localparam logic [1:0] WM_OFF    = 2'd2;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647)
            return 32'sh7fffffff;
        else if (v < -66'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

    function automatic logic signed [31:0] clamp32(input logic signed [65:0] v,
                                                   input logic signed [31:0] lo,
                                                   input logic signed [31:0] hi);
        if (v < 66'(lo))
            return lo;
        else if (v > 66'(hi))
            return hi;
        else
            return v[31:0];
    endfunction

endpackage

// File: sv/pwop_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwop_mul
// Shared signed multiplier: registered product, scaled and saturated output.
// ----------------------------------------------------------------------------
module pwop_mul #(
    parameter int FRAC_BITS = 16
) (
    input  logic                i_clk,
    input  logic signed [32:0]  i_a,
    input  logic signed [32:0]  i_b,
    output logic signed [31:0]  o_q
);
    import pwop_pkg::*;

    logic signed [65:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= 66'(i_a) * 66'(i_b);
    end

    // arithmetic shift floors towards minus infinity
    assign o_q = sat32(r_prod >>> FRAC_BITS);

endmodule

// File: sv/pwop_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwop_div
// Restoring fraction divider, one quotient bit per cycle; dividend < divisor.
// ----------------------------------------------------------------------------
module pwop_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [31:0]           i_num,
    input  logic [30:0]           i_den,
    output logic                  o_done,
    output logic [FRAC_BITS-1:0]  o_quo
);
    localparam int CW = $clog2(FRAC_BITS + 1);

    logic [31:0]          r_rem;
    logic [30:0]          r_den;
    logic [FRAC_BITS-1:0] r_quo;
    logic [CW-1:0]        r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [32:0]          w_sh;

    assign w_sh = {r_rem, 1'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(FRAC_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num;
            r_den <= i_den;
            r_quo <= '0;
        end else if (r_busy) begin
            if (w_sh >= 33'(r_den)) begin
                r_rem <= 32'(w_sh - 33'(r_den));
                r_quo <= {r_quo[FRAC_BITS-2:0], 1'b1};
            end else begin
                r_rem <= w_sh[31:0];
                r_quo <= {r_quo[FRAC_BITS-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

// File: sv/pid_with_overshoot_prediction.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_with_overshoot_prediction
// Q16.16 PID controller with anti-windup and overshoot prediction.
// ----------------------------------------------------------------------------
// In auto mode, a sample request far below the setpoint gives its result after
// the PRE and EVAL states. Any other sample also runs MULP, MULM, MULI, MULD,
// DRES, INTG and BASE, plus PRED for an overshoot prediction, DB1 and DB2 for
// the boosted derivative, AW1 and AW2 for conditional anti-windup and SCALE
// and SCL2 for output scaling. When the scale factor has to be divided out,
// the divider runs before the scaling. All gain and scaling products go one
// after another through a single registered multiplier. Initialize, reset
// and load requests finish in the accepting cycle. Input is stalled while a
// sample is in progress or its result is waiting, and is accepted again in
// the cycle after the result is taken. Configuration writes are always ready.
module pid_with_overshoot_prediction #(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_mode,
    input  logic signed [31:0] i_measured,
    input  logic signed [31:0] i_target,
    input  logic signed [31:0] i_preset_output,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_drive,
    output logic signed [31:0] o_p_part,
    output logic signed [31:0] o_i_part,
    output logic signed [31:0] o_d_part,
    output logic signed [31:0] o_integrator_out,
    output logic               o_full_drive,
    output logic               o_predicted
);
    import pwop_pkg::*;

    localparam logic signed [31:0] ONE_Q   = 32'sd1 <<< FRAC_BITS;
    localparam logic signed [31:0] FIFTH_Q = 32'((2 * (64'sd1 <<< FRAC_BITS) + 5) / 10);

    // configuration
    logic [30:0]        r_kp, r_ki, r_kd, r_pf, r_band;
    logic signed [31:0] r_lo, r_hi;
    logic [7:0]         r_opt;
    // controller state
    logic signed [31:0] r_prev_in, r_prev_err, r_integ;
    // sample working set
    t_state             r_state, n_state;
    logic signed [31:0] r_in, r_tgt, r_din, r_oerr, r_err, r_derr, r_pred;
    logic signed [31:0] r_pe, r_pm, r_it, r_d, r_p, r_base, r_f;
    logic               r_usep;
    // result
    logic               r_ovalid, r_full;
    logic signed [31:0] r_drive;

    logic               w_rev, w_dmeas, w_pen, w_auto;
    logic [1:0]         w_pmode, w_wmode;
    logic signed [32:0] w_ma, w_mb;
    logic signed [31:0] w_q;
    logic               w_div_start, w_div_done;
    logic [FRAC_BITS-1:0] w_quo;
    logic               w_in_acc, w_out_acc;

    logic signed [31:0] w_din0, w_din, w_oerr, w_err, w_derr, w_pred, w_perr;
    logic signed [31:0] w_perr2, w_boost, w_kd2, w_awin, w_proj, w_t, w_t2, w_base;
    logic signed [33:0] w_abs_oerr, w_over;
    logic               w_far, w_cand, w_usep, w_aw;

    assign w_pmode = r_opt[1:0];
    assign w_dmeas = r_opt[2];
    assign w_wmode = r_opt[4:3];
    assign w_rev   = r_opt[5];
    assign w_pen   = r_opt[6];
    assign w_auto  = r_opt[7];

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_out_acc   = r_ovalid && !i_out_stall;

    pwop_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
        .i_clk (i_clk),
        .i_a   (w_ma),
        .i_b   (w_mb),
        .o_q   (w_q)
    );

    pwop_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_over[31:0]),
        .i_den   (r_band),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    // datapath arithmetic
    always_comb begin
        w_din0     = sat32(66'(r_in) - 66'(r_prev_in));
        w_din      = w_rev ? sat32(-66'(w_din0)) : w_din0;
        w_oerr     = sat32(66'(r_tgt) - 66'(r_in));
        w_err      = w_rev ? sat32(-66'(w_oerr)) : w_oerr;
        w_derr     = sat32(66'(r_err) - 66'(r_prev_err));
        w_far      = (35'(r_oerr) * 35'sd2 > $signed(35'({1'b0, r_band})) * 35'sd3)
                     && (r_din >= 0);
        w_abs_oerr = (r_oerr < 0) ? -34'(r_oerr) : 34'(r_oerr);
        w_cand     = w_pen && (w_abs_oerr < 34'({1'b0, r_band})) && (r_din > 0);
        w_pred     = sat32(66'(r_in) + 66'(w_q));
        w_usep     = w_rev ? (w_pred < r_tgt) : (w_pred > r_tgt);
        w_perr     = sat32(66'(r_tgt) - 66'(w_pred));
        w_perr2    = w_rev ? sat32(-66'(w_perr)) : w_perr;
        w_boost    = w_q >>> 1;
        w_kd2      = sat32(66'({1'b0, r_kd}) + 66'(w_q));
        w_awin     = sat32(66'(r_it) + 66'(r_err));
        w_proj     = sat32(66'(r_pe) - 66'(r_pm) + 66'(w_q));
        w_aw       = ((w_proj > r_hi) && (r_derr > 0)) || ((w_proj < r_lo) && (r_derr < 0));
        w_t        = sat32(66'(r_integ) + 66'(r_it));
        w_t2       = sat32(66'(w_t) - 66'(r_pm));
        w_base     = clamp32(66'(r_integ) + 66'(r_p) + 66'(r_d), r_lo, r_hi);
        w_over     = 34'(r_pred) - 34'(r_tgt);

        w_ma = 33'({1'b0, r_pf});
        w_mb = 33'(r_din);
        case (r_state)
            ST_MULP: begin w_ma = 33'({1'b0, r_kp}); w_mb = 33'(r_err); end
            ST_MULM: begin w_ma = 33'({1'b0, r_kp}); w_mb = 33'(r_din); end
            ST_MULI: begin w_ma = 33'({1'b0, r_ki}); w_mb = 33'(r_err); end
            ST_MULD: begin
                if (!w_dmeas) begin
                    w_ma = 33'({1'b0, r_kd}); w_mb = 33'(r_derr);
                end else if (r_usep) begin
                    w_ma = 33'(r_din); w_mb = 33'({1'b0, r_pf});
                end else begin
                    w_ma = 33'({1'b0, r_kd}); w_mb = 33'(r_din);
                end
            end
            ST_DRES:  begin w_ma = 33'({1'b0, r_kd}); w_mb = 33'(w_boost); end
            ST_DB1:   begin w_ma = 33'(w_kd2); w_mb = 33'(r_din); end
            ST_AW1:   begin w_ma = 33'({1'b0, r_ki}); w_mb = 33'(w_awin); end
            ST_SCALE: begin w_ma = 33'(r_base); w_mb = 33'(r_f); end
            default: ;
        endcase
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        w_div_start = 1'b0;
        unique case (r_state)
            ST_IDLE:  if (w_in_acc && i_mode == OP_SAMPLE && w_auto) n_state = ST_PRE;
            ST_PRE:   n_state = ST_EVAL;
            ST_EVAL:  n_state = w_far ? ST_OUT : (w_cand ? ST_PRED : ST_MULP);
            ST_PRED:  n_state = ST_MULP;
            ST_MULP:  n_state = ST_MULM;
            ST_MULM:  n_state = ST_MULI;
            ST_MULI:  n_state = ST_MULD;
            ST_MULD:  n_state = ST_DRES;
            ST_DRES:  begin
                if (w_dmeas && r_usep)        n_state = ST_DB1;
                else if (w_wmode == WM_COND)  n_state = ST_AW1;
                else                          n_state = ST_INTG;
            end
            ST_DB1:   n_state = ST_DB2;
            ST_DB2:   n_state = (w_wmode == WM_COND) ? ST_AW1 : ST_INTG;
            ST_AW1:   n_state = ST_AW2;
            ST_AW2:   n_state = ST_INTG;
            ST_INTG:  n_state = ST_BASE;
            ST_BASE:  begin
                if (r_usep && r_band != '0 && w_over > 0) begin
                    if (w_over >= 34'({1'b0, r_band})) begin
                        n_state = ST_SCALE;
                    end else begin
                        n_state     = ST_DIV;
                        w_div_start = 1'b1;
                    end
                end else begin
                    n_state = ST_OUT;
                end
            end
            ST_DIV:   if (w_div_done) n_state = ST_SCALE;
            ST_SCALE: n_state = ST_SCL2;
            ST_SCL2:  n_state = ST_OUT;
            ST_OUT:   if (w_out_acc) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ovalid <= 1'b0;
            r_kp <= '0; r_ki <= '0; r_kd <= '0; r_pf <= '0;
            r_lo <= '0;
            r_hi <= 32'sd100 <<< FRAC_BITS;
            r_band <= 31'(ONE_Q);
            r_opt <= 8'd4;
            r_prev_in <= '0; r_prev_err <= '0; r_integ <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_KP:   r_kp   <= i_cfg_data[30:0];
                    CFG_KI:   r_ki   <= i_cfg_data[30:0];
                    CFG_KD:   r_kd   <= i_cfg_data[30:0];
                    CFG_LOW:  r_lo   <= i_cfg_data;
                    CFG_HIGH: r_hi   <= i_cfg_data;
                    CFG_PF:   r_pf   <= i_cfg_data[30:0];
                    CFG_BAND: r_band <= i_cfg_data[30:0];
                    CFG_OPT:  r_opt  <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (w_out_acc) r_ovalid <= 1'b0;
            if (w_in_acc) begin
                case (i_mode)
                    OP_INIT: begin
                        r_integ   <= clamp32(66'(i_preset_output), r_lo, r_hi);
                        r_prev_in <= i_measured;
                    end
                    OP_RESET: begin
                        r_prev_in <= '0;
                        r_integ   <= '0;
                    end
                    OP_LOAD: r_integ <= i_preset_output;
                    default: ;
                endcase
            end
            if (r_state == ST_EVAL && w_far) begin
                r_prev_in  <= r_in;
                r_prev_err <= r_err;
                r_ovalid   <= 1'b1;
            end
            if (r_state == ST_INTG)
                r_integ <= (w_wmode == WM_OFF) ? w_t2 : clamp32(66'(w_t2), r_lo, r_hi);
            if (r_state == ST_BASE) begin
                r_prev_in  <= r_in;
                r_prev_err <= r_err;
                if (n_state == ST_OUT) r_ovalid <= 1'b1;
            end
            if (r_state == ST_SCL2) r_ovalid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in  <= i_measured;
            r_tgt <= i_target;
        end
        case (r_state)
            ST_PRE: begin
                r_din  <= w_din;
                r_oerr <= w_oerr;
                r_err  <= w_err;
                r_usep <= 1'b0;
            end
            ST_EVAL: begin
                r_derr <= w_derr;
                if (w_far) begin
                    r_drive <= r_hi;
                    r_p <= '0; r_it <= '0; r_d <= '0;
                    r_full <= 1'b1;
                end else begin
                    r_full <= 1'b0;
                end
            end
            ST_PRED: begin
                r_pred <= w_pred;
                r_usep <= w_usep;
                if (w_usep) r_err <= w_perr2;
            end
            ST_MULM: r_pe <= w_q;
            ST_MULI: begin
                if (w_pmode == PM_ERR) begin
                    r_pm <= '0;
                end else if (w_pmode == PM_MEAS) begin
                    r_pe <= '0;
                    r_pm <= w_q;
                end else begin
                    r_pe <= r_pe >>> 1;
                    r_pm <= w_q >>> 1;
                end
            end
            ST_MULD: r_it <= w_q;
            ST_DRES: begin
                if (!w_dmeas)     r_d <= w_q;
                else if (!r_usep) r_d <= sat32(-66'(w_q));
            end
            ST_DB2:  r_d <= sat32(-66'(w_q));
            ST_AW2:  if (w_aw && r_ki != '0)
                         r_it <= clamp32(66'(w_proj), sat32(-66'(r_hi)), r_hi);
            ST_INTG: r_p <= sat32(66'(r_pe) - 66'(r_pm));
            ST_BASE: begin
                r_base  <= w_base;
                r_drive <= w_base;
                r_f     <= FIFTH_Q;
            end
            ST_DIV: begin
                if (w_div_done) begin
                    if (ONE_Q - 32'(w_quo) < FIFTH_Q) r_f <= FIFTH_Q;
                    else r_f <= ONE_Q - 32'(w_quo);
                end
            end
            ST_SCL2: r_drive <= w_q;
            default: ;
        endcase
    end

    assign o_out_valid      = r_ovalid;
    assign o_drive          = r_drive;
    assign o_p_part         = r_p;
    assign o_i_part         = r_it;
    assign o_d_part         = r_d;
    assign o_integrator_out = r_integ;
    assign o_full_drive     = r_full;
    assign o_predicted      = r_usep && !r_full;

    a_valid_in_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_state == ST_OUT)
        else $error("result valid outside output state");
    a_div_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> r_state == ST_DIV)
        else $error("divider finished outside divide state");
    a_full_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_full_drive && o_predicted))
        else $error("full drive and prediction both flagged");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid && $stable(o_drive))
        else $error("stalled result changed");

endmodule
